[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the running statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, c)
`define ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

[rtl/rsw_pkg.sv]
// ----------------------------------------------------------------------------
// rsw_pkg
// Types and constants shared by the running statistics block.
// ----------------------------------------------------------------------------
`default_nettype none
package rsw_pkg;
    localparam int SAMPLE_BITS = 32;
    localparam int TIME_BITS   = 48;
    localparam int FRAC_BITS   = 16;
    localparam int MEAN_BITS   = 48;
    localparam int M2_BITS     = 64;
    localparam int CNT_BITS    = 32;
    localparam int SQRT_BITS   = 41;
    localparam int DIV_STEPS   = 64;
    localparam int MUL_STEPS   = 7;

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_BEGIN = 3'd1;
    localparam logic [2:0] REQ_END   = 3'd2;
    localparam logic [2:0] REQ_PAIR  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] sample_value;
        logic [47:0]        time_begin;
        logic [47:0]        time_end;
    } req_t;

    typedef struct packed {
        logic               sample_taken;
        logic signed [31:0] last_sample;
        logic signed [31:0] min_sample;
        logic signed [31:0] max_sample;
        logic signed [47:0] mean_fixed;
        logic [47:0]        stddev_fixed;
        logic [31:0]        sample_count;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic add;
        logic clear;
        logic mark;
        logic unmark;
        logic load_mean_div;
        logic mean_step;
        logic mean_done;
        logic mul_step;
        logic load_m2;
        logic load_sd_div;
        logic sd_step;
        logic load_sqrt;
        logic sqrt_step;
    } cmd_t;

    typedef struct packed {
        logic begin_marked;
        logic step_last;
        logic count_zero;
    } sts_t;
endpackage
`default_nettype wire

[rtl/running_stats_welford_core.sv]
// ----------------------------------------------------------------------------
// running_stats_welford_core
// Welford running mean, deviation, min, max and count over signed samples.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    rsw_pkg::req_t
// m_       out  m_valid/m_ready    rsw_pkg::rsp_t
// A sample request runs the mean divide, the mean update, the M2 product, the M2
// update, the M2/count divide, the square-root load and the square root before
// m_valid; other requests go straight to the M2/count divide.
// One request at a time; s_ready returns the cycle after the result is taken.
// Reset zeroes last, min, max, mean, M2 and count and the begin mark; the deviation is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module running_stats_welford_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rsw_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rsw_pkg::rsp_t      m_data
);
    import rsw_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic        taken;
    req_t        req_reg;
    logic [31:0] last_w, min_w, max_w, cnt_w;
    logic [47:0] mean_w, sd_w;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    rsw_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .req_type(s_data.req_type), .m_valid(m_valid), .m_ready(m_ready),
        .taken(taken), .sts(sts), .cmd(cmd)
    );

    rsw_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .req(cmd.start ? s_data : req_reg),
        .cmd(cmd), .sts(sts), .last_o(last_w), .min_o(min_w), .max_o(max_w),
        .mean_o(mean_w), .sd_o(sd_w), .cnt_o(cnt_w)
    );

    assign m_data = '{sample_taken: taken, last_sample: last_w, min_sample: min_w,
                      max_sample: max_w, mean_fixed: mean_w, stddev_fixed: sd_w,
                      sample_count: cnt_w};

    `ASSERT_IMPLIES(a_excl, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `ASSERT_IMPLIES(a_cnt0, aclk, aresetn, m_valid && m_data.sample_count == 32'd0,
        m_data.stddev_fixed == 48'd0)
endmodule
`default_nettype wire

[rtl/rsw_ctrl.sv]
// ----------------------------------------------------------------------------
// rsw_ctrl
// Sequencer: decode request; for samples run the mean divide, M2 product and update;
// for every request run the M2/count divide and square root, then hand the result out.
// ----------------------------------------------------------------------------
`default_nettype none
module rsw_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    req_type,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               taken,
    input  wire rsw_pkg::sts_t sts,
    output rsw_pkg::cmd_t      cmd
);
    import rsw_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MDIV = 4'd1;
    localparam logic [3:0] ST_MEAN = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_M2   = 4'd4;
    localparam logic [3:0] ST_SDIV = 4'd5;
    localparam logic [3:0] ST_SQLD = 4'd6;
    localparam logic [3:0] ST_SQRT = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       taken_reg, taken_next;
    logic       acc;
    logic       adds;

    assign acc = s_valid && s_ready;
    always_comb begin
        unique case (req_type)
            REQ_ADD, REQ_PAIR: adds = 1'b1;
            REQ_END:           adds = sts.begin_marked;
            default:           adds = 1'b0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign taken   = taken_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        taken_next = taken_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.start  = 1'b1;
                    cmd.add    = adds;
                    cmd.clear  = (req_type == REQ_CLEAR);
                    cmd.mark   = (req_type == REQ_BEGIN);
                    cmd.unmark = (req_type == REQ_END) && sts.begin_marked;
                    taken_next = adds;
                    if (adds) begin
                        cmd.load_mean_div = 1'b1;
                        state_next = ST_MDIV;
                    end else begin
                        cmd.load_sd_div = 1'b1;
                        state_next = ST_SDIV;
                    end
                end
            end
            ST_MDIV: begin
                cmd.mean_step = 1'b1;
                if (sts.step_last) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                cmd.mean_done = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.step_last) begin
                    state_next = ST_M2;
                end
            end
            ST_M2: begin
                cmd.load_m2 = 1'b1;
                cmd.load_sd_div = 1'b1;
                state_next = ST_SDIV;
            end
            ST_SDIV: begin
                cmd.sd_step = 1'b1;
                if (sts.step_last) begin
                    state_next = ST_SQLD;
                end
            end
            ST_SQLD: begin
                cmd.load_sqrt = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.step_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            taken_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            taken_reg <= taken_next;
        end
    end
endmodule
`default_nettype wire

[rtl/rsw_dp.sv]
// ----------------------------------------------------------------------------
// rsw_dp
// Datapath: statistics registers, shared restoring divider, digit-serial
// M2 product and bit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none
module rsw_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rsw_pkg::req_t req,
    input  wire rsw_pkg::cmd_t cmd,
    output rsw_pkg::sts_t      sts,
    output logic [31:0]        last_o,
    output logic [31:0]        min_o,
    output logic [31:0]        max_o,
    output logic [47:0]        mean_o,
    output logic [47:0]        sd_o,
    output logic [31:0]        cnt_o
);
    import rsw_pkg::*;

    logic signed [31:0] last_reg, min_reg, max_reg;
    logic signed [47:0] mean_reg;
    logic [63:0]        m2_reg;
    logic [31:0]        cnt_reg;
    logic               mark_reg;
    logic [47:0]        stamp_reg;
    logic signed [49:0] xs_reg;
    logic               dneg_reg;
    logic signed [49:0] delta_reg;
    logic [63:0]        q_reg;
    logic [32:0]        rem_reg;
    logic [63:0]        dvd_reg;
    logic [6:0]         step_reg;
    logic [55:0]        mula_reg;
    logic [49:0]        mulb_reg;
    logic [99:0]        prod_reg;
    logic               upd_reg;
    logic [40:0]        root_reg;
    logic [81:0]        rsq_reg;
    logic [79:0]        rad_reg;
    logic [47:0]        sd_reg;

    logic signed [31:0] x;
    logic signed [48:0] dur;
    logic [47:0]        beg;
    logic [31:0]        cnt_new;
    logic signed [49:0] delta;
    logic [63:0]        dmag;
    logic [33:0]        rtry;
    logic signed [49:0] mean_new;
    logic signed [49:0] delta2;
    logic [49:0]        m1, m2v;
    logic [57:0]        pp;
    logic [83:0]        term;
    logic [64:0]        m2sum;
    logic [63:0]        m2_upd;
    logic [40:0]        cand;
    logic [81:0]        sq;
    logic               sq_fit;

    always_comb begin
        beg = (req.req_type == REQ_END) ? stamp_reg : req.time_begin;
        dur = $signed({1'b0, req.time_end}) - $signed({1'b0, beg});
        if (req.req_type == REQ_ADD) begin
            x = req.sample_value;
        end else if (dur > 49'sd2147483647) begin
            x = 32'sh7fffffff;
        end else if (dur < -49'sd2147483648) begin
            x = 32'sh80000000;
        end else begin
            x = dur[31:0];
        end
    end

    assign cnt_new = (cnt_reg == '1) ? cnt_reg : cnt_reg + 32'd1;
    assign delta   = {{2{x[31]}}, x, 16'd0} - {{2{mean_reg[47]}}, mean_reg};
    assign dmag    = delta[49] ? 64'(-delta) : 64'(delta);

    assign rtry = {rem_reg, dvd_reg[63]} - {2'b0, cnt_reg};
    assign mean_new = {{2{mean_reg[47]}}, mean_reg}
                      + (dneg_reg ? -$signed({1'b0, q_reg[48:0]})
                                  : $signed({1'b0, q_reg[48:0]}));
    assign delta2 = xs_reg - mean_new;
    assign m1  = delta_reg[49] ? -delta_reg : delta_reg;
    assign m2v = delta2[49] ? -delta2 : delta2;
    assign pp  = mulb_reg * mula_reg[55:48];
    assign term = prod_reg[99:16];
    assign m2sum = {1'b0, m2_reg} + ((|term[83:64]) ? 65'h0ffffffffffffffff
                                                    : {1'b0, term[63:0]});
    assign m2_upd = !upd_reg ? m2_reg : (m2sum[64] ? '1 : m2sum[63:0]);
    assign cand = root_reg | (41'd1 << step_reg[5:0]);
    assign sq   = rsq_reg + ({41'd0, root_reg} << (step_reg[5:0] + 6'd1))
                  + (82'd1 << {step_reg[5:0], 1'b0});
    assign sq_fit = ({2'b0, rad_reg} >= sq);

    assign sts = '{begin_marked: mark_reg, step_last: (step_reg == '0),
                   count_zero: (cnt_reg == '0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0; min_reg <= '0; max_reg <= '0;
            mean_reg <= '0; m2_reg <= '0; cnt_reg <= '0;
            mark_reg <= 1'b0; stamp_reg <= '0;
        end else begin
            if (cmd.mark) begin
                mark_reg  <= 1'b1;
                stamp_reg <= req.time_begin;
            end
            if (cmd.unmark) begin
                mark_reg <= 1'b0;
            end
            if (cmd.clear) begin
                last_reg <= '0; min_reg <= '0; max_reg <= '0;
                mean_reg <= '0; m2_reg <= '0; cnt_reg <= '0;
            end
            if (cmd.add) begin
                last_reg <= x;
                min_reg  <= (cnt_reg == '0 || x < min_reg) ? x : min_reg;
                max_reg  <= (cnt_reg == '0 || x > max_reg) ? x : max_reg;
                cnt_reg  <= cnt_new;
            end
            if (cmd.mean_done) begin
                mean_reg <= mean_new[47:0];
            end
            if (cmd.load_m2) begin
                m2_reg <= m2_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add) begin
            xs_reg    <= {{2{x[31]}}, x, 16'd0};
            delta_reg <= delta;
            dneg_reg  <= delta[49];
        end
        if (cmd.load_mean_div) begin
            dvd_reg  <= dmag;
            rem_reg  <= '0;
            q_reg    <= '0;
            step_reg <= 7'(DIV_STEPS - 1);
        end else if (cmd.load_sd_div) begin
            dvd_reg  <= cmd.load_m2 ? m2_upd : m2_reg;
            rem_reg  <= '0;
            q_reg    <= '0;
            step_reg <= 7'(DIV_STEPS - 1);
        end else if (cmd.mean_step || cmd.sd_step) begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            if (!rtry[33]) begin
                rem_reg <= rtry[32:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[31:0], dvd_reg[63]};
                q_reg   <= {q_reg[62:0], 1'b0};
            end
            if (!sts.step_last) begin
                step_reg <= step_reg - 7'd1;
            end
        end else if (cmd.mean_done) begin
            mula_reg <= {6'd0, m1};
            mulb_reg <= m2v;
            prod_reg <= '0;
            upd_reg  <= delta_reg != '0 && delta2 != '0
                        && delta_reg[49] == delta2[49];
            step_reg <= 7'(MUL_STEPS - 1);
        end else if (cmd.mul_step) begin
            prod_reg <= {prod_reg[91:0], 8'd0} + {42'd0, pp};
            mula_reg <= {mula_reg[47:0], 8'd0};
            if (!sts.step_last) begin
                step_reg <= step_reg - 7'd1;
            end
        end else if (cmd.load_sqrt) begin
            root_reg <= '0;
            rsq_reg  <= '0;
            rad_reg  <= (cnt_reg == '0) ? 80'd0 : {q_reg, 16'd0};
            step_reg <= 7'(SQRT_BITS - 1);
        end else if (cmd.sqrt_step) begin
            if (sq_fit) begin
                root_reg <= cand;
                rsq_reg  <= sq;
            end
            if (step_reg == '0) begin
                sd_reg <= sq_fit ? {7'd0, cand} : {7'd0, root_reg};
            end else begin
                step_reg <= step_reg - 7'd1;
            end
        end
    end

    assign last_o = last_reg;
    assign min_o  = min_reg;
    assign max_o  = max_reg;
    assign mean_o = mean_reg;
    assign sd_o   = sd_reg;
    assign cnt_o  = cnt_reg;
endmodule
`default_nettype wire

[sim/stats_checker.sv]
// ----------------------------------------------------------------------------
// stats_checker
// Watches the request and result channels of the running statistics core,
// predicts each result from its own copy of the statistics, and compares
// every field of each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module stats_checker
    import rsw_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_ready,
    input  req_t  s_data,
    input  logic  m_valid,
    input  logic  m_ready,
    input  rsp_t  m_data,
    output int    fail_count,
    output int    pending,
    output int    taken_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES = '1;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    longint    st_last, st_min, st_max, st_mean;
    logic [63:0] st_m2;
    logic [31:0] st_count;
    logic      st_marked;
    logic [47:0] st_stamp;
    rsp_t      expected_q[$];

    function automatic longint duration(logic [47:0] b, logic [47:0] e);
        longint d;
        d = longint'({16'd0, e}) - longint'({16'd0, b});
        if (d > SMAX) return SMAX;
        if (d < SMIN) return SMIN;
        return d;
    endfunction

    function automatic logic [63:0] std_dev();
        logic [63:0]  v;
        logic [127:0] target, c;
        logic [63:0]  r;
        if (st_count == 0) return 0;
        v = st_m2 / {32'd0, st_count};
        target = {64'd0, v} << FRAC_BITS;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c = {64'd0, r | (64'd1 << b)};
            if (c * c <= target) r = c[63:0];
        end
        return r;
    endfunction

    task automatic fold_sample(longint x);
        longint xs, delta, delta2;
        logic [127:0] prod;
        logic [63:0] term, md, md2;
        xs = x * 65536;
        st_last = x;
        if (st_count == 0) begin
            st_min = x;
            st_max = x;
        end else begin
            if (x < st_min) st_min = x;
            if (x > st_max) st_max = x;
        end
        if (st_count != 32'hFFFF_FFFF) st_count++;
        delta = xs - st_mean;
        st_mean = st_mean + delta / longint'({32'd0, st_count});
        delta2 = xs - st_mean;
        if (delta != 0 && delta2 != 0 && ((delta < 0) == (delta2 < 0))) begin
            md = delta < 0 ? -delta : delta;
            md2 = delta2 < 0 ? -delta2 : delta2;
            prod = ({64'd0, md} * {64'd0, md2}) >> FRAC_BITS;
            term = prod[127:64] != 0 ? ALL_ONES : prod[63:0];
            st_m2 = (st_m2 > ALL_ONES - term) ? ALL_ONES : st_m2 + term;
        end
    endtask

    task automatic predict(req_t r);
        rsp_t e;
        logic took;
        took = 0;
        case (r.req_type)
            REQ_ADD: begin
                fold_sample(longint'(r.sample_value));
                took = 1;
            end
            REQ_BEGIN: begin
                st_stamp = r.time_begin;
                st_marked = 1;
            end
            REQ_END: begin
                if (st_marked) begin
                    fold_sample(duration(st_stamp, r.time_end));
                    st_marked = 0;
                    took = 1;
                end
            end
            REQ_PAIR: begin
                fold_sample(duration(r.time_begin, r.time_end));
                took = 1;
            end
            REQ_CLEAR: begin
                st_last = 0; st_min = 0; st_max = 0; st_mean = 0;
                st_m2 = 0; st_count = 0;
            end
            default: ;
        endcase
        e.sample_taken = took;
        e.last_sample  = st_last[31:0];
        e.min_sample   = st_min[31:0];
        e.max_sample   = st_max[31:0];
        e.mean_fixed   = st_mean[47:0];
        e.stddev_fixed = std_dev();
        e.sample_count = st_count;
        if (took) taken_count++;
        expected_q.push_back(e);
    endtask

    task automatic compare(rsp_t a);
        rsp_t e;
        if (expected_q.size() == 0) begin
            $error("unexpected result");
            fail_count++;
            return;
        end
        e = expected_q.pop_front();
        if (a.sample_taken !== e.sample_taken) begin
            $error("sample_taken exp %0d got %0d", e.sample_taken, a.sample_taken);
            fail_count++;
        end
        if (a.last_sample !== e.last_sample) begin
            $error("last_sample exp %0d got %0d", e.last_sample, a.last_sample);
            fail_count++;
        end
        if (a.min_sample !== e.min_sample) begin
            $error("min_sample exp %0d got %0d", e.min_sample, a.min_sample);
            fail_count++;
        end
        if (a.max_sample !== e.max_sample) begin
            $error("max_sample exp %0d got %0d", e.max_sample, a.max_sample);
            fail_count++;
        end
        if (a.mean_fixed !== e.mean_fixed) begin
            $error("mean_fixed exp %0d got %0d", e.mean_fixed, a.mean_fixed);
            fail_count++;
        end
        if (a.stddev_fixed !== e.stddev_fixed) begin
            $error("stddev_fixed exp %0d got %0d", e.stddev_fixed, a.stddev_fixed);
            fail_count++;
        end
        if (a.sample_count !== e.sample_count) begin
            $error("sample_count exp %0d got %0d", e.sample_count, a.sample_count);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        taken_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            st_last = 0; st_min = 0; st_max = 0; st_mean = 0;
            st_m2 = 0; st_count = 0; st_marked = 0; st_stamp = 0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) predict(s_data);
            if (m_valid && m_ready) compare(m_data);
        end
        pending = expected_q.size();
    end
endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests into the running statistics core with
// random gaps and result stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import rsw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1430;
    localparam longint LIMIT = 3_000_000;

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready;
    req_t s_data;
    rsp_t m_data;
    int   fail_count, pending, taken_count, sent;
    longint cycles;
    logic [47:0] mark_stamp;

    running_stats_welford_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    stats_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .taken_count(taken_count)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout");
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // stall results at random, with calm stretches
    initial begin
        int w;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic send(logic [2:0] t, logic [31:0] v, logic [47:0] b,
                        logic [47:0] e, bit gaps);
        int w;
        w = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 11) : 0;
        if (w > 0) begin
            s_valid <= 0;
            repeat (w) @(negedge aclk);
        end
        s_data.req_type <= t;
        s_data.sample_value <= v;
        s_data.time_begin <= b;
        s_data.time_end <= e;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return 32'($urandom_range(0, 100000));
        endcase
    endfunction

    function automatic logic [47:0] rand_stamp();
        return 48'({$urandom(), $urandom()});
    endfunction

    initial begin
        logic [2:0] t;
        logic [47:0] b;
        sent = 0;
        s_valid = 0;
        s_data = '0;
        aresetn = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        send(REQ_END, 0, 0, 48'h1234, 0);
        send(REQ_ADD, 32'h7FFF_FFFF, 0, 0, 0);
        send(REQ_ADD, 32'h8000_0000, 0, 0, 0);
        send(REQ_ADD, 32'h7FFF_FFFF, 0, 0, 0);
        send(REQ_ADD, 0, 0, 0, 0);
        send(REQ_ADD, 32'hFFFF_FFFF, 0, 0, 0);
        send(REQ_ADD, 32'd1, 0, 0, 0);
        send(REQ_BEGIN, 0, 48'd1000, 0, 0);
        send(REQ_BEGIN, 0, 48'd2000, 0, 0);
        send(REQ_CLEAR, 0, 0, 0, 0);
        send(REQ_END, 0, 0, 48'd2500, 0);
        send(REQ_END, 0, 0, 48'd3000, 0);
        send(REQ_PAIR, 0, 48'd0, 48'hFFFF_FFFF_FFFF, 0);
        send(REQ_PAIR, 0, 48'hFFFF_FFFF_FFFF, 48'd0, 0);
        send(REQ_PAIR, 0, 48'd500, 48'd100, 0);
        send(REQ_PAIR, 0, 48'd7, 48'd7, 0);
        send(3'd5, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 0);
        send(3'd6, 0, 0, 0, 0);
        send(3'd7, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
        send(REQ_ADD, 32'd3, 0, 0, 0);
        send(REQ_ADD, 32'd4, 0, 0, 0);
        send(REQ_ADD, 32'd4, 0, 0, 0);
        send(REQ_CLEAR, 0, 0, 0, 0);
        s_valid <= 0;

        // hold off until every result has come back
        while (pending != 0) @(negedge aclk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            t = 3'($urandom_range(0, 99) < 45 ? 0 : $urandom_range(1, 7));
            if (t == REQ_CLEAR && $urandom_range(0, 3) != 0) t = REQ_ADD;
            if (t == REQ_BEGIN && $urandom_range(0, 4) != 0) begin
                b = $urandom_range(0, 1) ? rand_stamp() : 48'($urandom_range(0, 1 << 20));
                send(REQ_BEGIN, $urandom(), b, rand_stamp(), 1);
                send(REQ_END, $urandom(), rand_stamp(),
                     $urandom_range(0, 3) == 0 ? rand_stamp()
                                                : b + 48'($urandom_range(0, 1 << 18)), 1);
                i++;
            end else if (t == REQ_PAIR) begin
                b = rand_stamp();
                send(t, $urandom(), b,
                     $urandom_range(0, 1) ? rand_stamp() : b + 48'($urandom_range(0, 5000)), 1);
            end else begin
                send(t, rand_sample(), rand_stamp(), rand_stamp(), 1);
            end
        end
        s_valid <= 0;

        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        $display("Sent %0d requests, %0d of them added samples.", sent, taken_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/rsw_pkg.sv
rtl/rsw_ctrl.sv
rtl/rsw_dp.sv
rtl/running_stats_welford_core.sv
sim/stats_checker.sv
sim/testbench.sv
